/* design/front_panel_menu_controller_core_defines.svh */
// Assertion macros for the front panel menu controller.
// Used by the top level; no other dependencies.
`ifndef FRONT_PANEL_MENU_CONTROLLER_CORE_DEFINES_SVH
`define FRONT_PANEL_MENU_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define FPMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpmc assertion failed");

`define FPMC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpmc assertion failed");

`else

`define FPMC_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define FPMC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/fpmc_pkg.sv */
// Types and constants of the front panel menu controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package fpmc_pkg;

    localparam logic [7:0] KEY_MUTE    = 8'h0e;
    localparam logic [7:0] KEY_VOLUP   = 8'h0c;
    localparam logic [7:0] KEY_VOLDOWN = 8'h0d;
    localparam logic [7:0] KEY_OK      = 8'h19;
    localparam logic [7:0] KEY_CHUP    = 8'h0a;
    localparam logic [7:0] KEY_CHDOWN  = 8'h0b;

    localparam logic [15:0] REMOTE_ADDRESS_RESET = 16'hff20;
    localparam logic [15:0] TICK_DIVIDE_RESET    = 16'd500;
    localparam logic [7:0]  RETURN_LIMIT_RESET   = 8'd70;

    localparam logic [7:0] TIMER_MAX = 8'hff;

    localparam logic [1:0] CFG_REMOTE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_TICK_DIVIDE    = 2'd1;
    localparam logic [1:0] CFG_RETURN_LIMIT   = 2'd2;

    localparam logic [1:0] MODE_VOLUME = 2'd0;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_UP   = 2'd1,
        CMD_DEC  = 2'd2,
        CMD_NEXT = 2'd3
    } cmd_t;

    typedef struct packed {
        logic        ir_valid;
        logic [15:0] ir_address;
        logic [7:0]  ir_command;
        logic        ir_repeat;
        logic        enc_a;
        logic        enc_b;
        logic        button_level;
    } in_word_t;

    typedef struct packed {
        cmd_t cmd;
        logic mute_toggle;
        logic force_volume;
    } ir_dec_t;

    typedef struct packed {
        logic wrap;
        logic led;
    } presc_t;

    typedef struct packed {
        logic [1:0] adjust;
        logic [1:0] mode;
        logic       mode_switched;
        logic       muted;
        logic       mute_toggled;
    } result_t;

endpackage

`default_nettype wire

/* design/front_panel_menu_controller_core.sv */
// An accepted input word passes through the input register, then the result register.
// One word per cycle unless stalled; input reg, single-pass logic, result register.
// in_stall rises only while the input register holds a word and the result is stalled.
// Reset (rst_n low, asynchronous): empty pipeline, configuration at its defaults,
// volume mode, unmuted, prescaler LED bit high, its count and return timer cleared.
`default_nettype none

`include "front_panel_menu_controller_core_defines.svh"

module front_panel_menu_controller_core
    import fpmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        ir_valid,
    input  logic [15:0] ir_address,
    input  logic [7:0]  ir_command,
    input  logic        ir_repeat,
    input  logic        enc_a,
    input  logic        enc_b,
    input  logic        button_level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  adjust,
    output logic [1:0]  mode,
    output logic        mode_switched,
    output logic        muted,
    output logic        mute_toggled,
    output logic        heartbeat
);

    logic [15:0] remote_address_reg;
    logic [15:0] tick_divide_reg;
    logic [7:0]  return_limit_reg;

    logic        stage_valid_reg;
    logic        stage_valid_next;
    in_word_t    stage_word_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     result_reg;
    logic        heartbeat_reg;

    logic        out_free;
    logic        advance;
    logic        take;
    ir_dec_t     dec;
    presc_t      presc;
    result_t     result;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = stage_valid_reg && out_free;
    assign in_stall = stage_valid_reg && !out_free;
    assign take     = in_valid && !in_stall;

    assign stage_valid_next = take || (stage_valid_reg && !advance);
    assign out_valid_next   = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remote_address_reg <= REMOTE_ADDRESS_RESET;
            tick_divide_reg    <= TICK_DIVIDE_RESET;
            return_limit_reg   <= RETURN_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_REMOTE_ADDRESS: remote_address_reg <= cfg_data;
                CFG_TICK_DIVIDE:    tick_divide_reg    <= cfg_data;
                CFG_RETURN_LIMIT:   return_limit_reg   <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_word_reg <= '{ir_valid: ir_valid, ir_address: ir_address,
                                ir_command: ir_command, ir_repeat: ir_repeat,
                                enc_a: enc_a, enc_b: enc_b,
                                button_level: button_level};
        end
        if (advance)
        begin
            result_reg    <= result;
            heartbeat_reg <= presc.led;
        end
    end

    fpmc_ir_decode u_ir_decode (
        .word           (stage_word_reg),
        .remote_address (remote_address_reg),
        .dec            (dec)
    );

    fpmc_prescaler u_prescaler (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .tick_divide (tick_divide_reg),
        .presc       (presc)
    );

    fpmc_menu_state u_menu_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (advance),
        .word         (stage_word_reg),
        .dec          (dec),
        .wrap         (presc.wrap),
        .return_limit (return_limit_reg),
        .result       (result)
    );

    assign out_valid     = out_valid_reg;
    assign adjust        = result_reg.adjust;
    assign mode          = result_reg.mode;
    assign mode_switched = result_reg.mode_switched;
    assign muted         = result_reg.muted;
    assign mute_toggled  = result_reg.mute_toggled;
    assign heartbeat     = heartbeat_reg;

    `FPMC_ASSERT_IMP(a_stall_needs_word, clk, rst_n, in_stall, stage_valid_reg)
    `FPMC_ASSERT_NXT(a_advance_fills_out, clk, rst_n, advance, out_valid_reg)
    `FPMC_ASSERT_IMP(a_next_has_no_adjust, clk, rst_n, out_valid && mode_switched, adjust == 2'(CMD_NONE))
    `FPMC_ASSERT_IMP(a_mute_forces_volume, clk, rst_n, out_valid && mute_toggled && !mode_switched, mode == MODE_VOLUME)

endmodule

`default_nettype wire

/* design/fpmc_ir_decode.sv */
// IR frame decoder: address match and key code to command.
// Depends on fpmc_pkg.
`default_nettype none

module fpmc_ir_decode
    import fpmc_pkg::*;
(
    input  in_word_t    word,
    input  logic [15:0] remote_address,
    output ir_dec_t     dec
);

    logic hit;

    assign hit = word.ir_valid && (word.ir_address == remote_address);

    always_comb
    begin
        dec = '{cmd: CMD_NONE, mute_toggle: 1'b0, force_volume: 1'b0};
        if (hit)
        begin
            case (word.ir_command)
                KEY_MUTE:
                begin
                    dec.mute_toggle  = !word.ir_repeat;
                    dec.force_volume = !word.ir_repeat;
                end
                KEY_VOLUP:
                begin
                    dec.force_volume = word.ir_repeat;
                    dec.cmd          = word.ir_repeat ? CMD_UP : CMD_NONE;
                end
                KEY_VOLDOWN:
                begin
                    dec.force_volume = word.ir_repeat;
                    dec.cmd          = word.ir_repeat ? CMD_DEC : CMD_NONE;
                end
                KEY_CHUP:
                    dec.cmd = word.ir_repeat ? CMD_UP : CMD_NONE;
                KEY_CHDOWN:
                    dec.cmd = word.ir_repeat ? CMD_DEC : CMD_NONE;
                KEY_OK:
                    dec.cmd = word.ir_repeat ? CMD_NONE : CMD_NEXT;
                default:
                    dec.cmd = CMD_NONE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/fpmc_prescaler.sv */
// Tick prescaler and heartbeat LED.
// Depends on fpmc_pkg.
`default_nettype none

module fpmc_prescaler
    import fpmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic [15:0] tick_divide,
    output presc_t      presc
);

    logic [15:0] tick_count_reg;
    logic [15:0] tick_count_next;
    logic [15:0] tick_inc;
    logic        led_reg;

    assign tick_inc        = tick_count_reg + 16'd1;
    assign presc.wrap      = (tick_inc == tick_divide);
    assign presc.led       = led_reg ^ presc.wrap;
    assign tick_count_next = presc.wrap ? 16'd0 : tick_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= 16'd0;
            led_reg        <= 1'b1;
        end
        else if (fire)
        begin
            tick_count_reg <= tick_count_next;
            led_reg        <= presc.led;
        end
    end

endmodule

`default_nettype wire

/* design/fpmc_menu_state.sv */
// Encoder and button edges, command merge, menu mode, mute and return timer.
// Depends on fpmc_pkg; takes decoded IR and the prescaler wrap.
`default_nettype none

module fpmc_menu_state
    import fpmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  in_word_t   word,
    input  ir_dec_t    dec,
    input  logic       wrap,
    input  logic [7:0] return_limit,
    output result_t    result
);

    logic       a_prev_reg;
    logic       pressed_prev_reg;
    logic       mute_reg;
    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic [7:0] timer_reg;
    logic [7:0] timer_next;
    logic       pressed;
    cmd_t       cmd;
    logic [1:0] mode_a;
    logic [1:0] mode_b;
    logic [7:0] timer_a;
    logic [7:0] timer_b;

    assign pressed = ~word.button_level;

    always_comb
    begin
        cmd = dec.cmd;
        if (word.enc_a != a_prev_reg)
        begin
            cmd = (word.enc_a == word.enc_b) ? CMD_UP : CMD_DEC;
        end
        if (pressed && !pressed_prev_reg)
        begin
            cmd = CMD_NEXT;
        end

        mode_a = dec.force_volume ? MODE_VOLUME : mode_reg;
        mode_b = (cmd == CMD_NEXT) ? mode_a + 2'd1 : mode_a;

        timer_a = timer_reg;
        if (wrap && timer_reg != 8'd0 && timer_reg != TIMER_MAX)
        begin
            timer_a = timer_reg + 8'd1;
        end
        timer_b = (cmd != CMD_NONE) ? 8'd1 : timer_a;

        mode_next  = mode_b;
        timer_next = timer_b;
        if (mode_b != MODE_VOLUME && timer_b > return_limit)
        begin
            mode_next  = MODE_VOLUME;
            timer_next = 8'd0;
        end

        result.adjust        = (cmd == CMD_UP || cmd == CMD_DEC) ? cmd : CMD_NONE;
        result.mode          = mode_next;
        result.mode_switched = (cmd == CMD_NEXT);
        result.muted         = mute_reg ^ dec.mute_toggle;
        result.mute_toggled  = dec.mute_toggle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_prev_reg       <= 1'b1;
            pressed_prev_reg <= 1'b0;
            mute_reg         <= 1'b0;
            mode_reg         <= MODE_VOLUME;
            timer_reg        <= 8'd0;
        end
        else if (fire)
        begin
            a_prev_reg       <= word.enc_a;
            pressed_prev_reg <= pressed;
            mute_reg         <= result.muted;
            mode_reg         <= mode_next;
            timer_reg        <= timer_next;
        end
    end

endmodule

`default_nettype wire
